@@ rtl/lct_pkg.sv @@
// Package for the LRU channel table: field widths, command codes, queue item
// and sequencer state types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lct_pkg;

	localparam int ID_W    = 32;
	localparam int STAMP_W = 48;
	localparam int CFG_W   = 5;
	localparam int ENTRY_W = ID_W + STAMP_W;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	localparam logic [CFG_W-1:0] MAX_CH_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_TOUCH = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// One classified transaction waiting for the back end
	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   id;
		logic [CFG_W-1:0]  limit;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_FINISH
	} bk_state_t;

endpackage

`default_nettype wire

@@ rtl/lct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/lct_front.sv @@
// Front end: holds the channel limit register, accepts and decodes commands
// and queues them for the back end. Depends on lct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lct_front #(
	parameter int CAPACITY = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  command,
	input  wire logic [lct_pkg::ID_W-1:0]    channel_id,
	input  wire logic                        cfg_we,
	input  wire logic [lct_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                             q_valid,
	output lct_pkg::item_t                   q_item,
	input  wire logic                        q_pop
);

	logic [lct_pkg::CFG_W-1:0] max_ch_q;
	logic [lct_pkg::CFG_W-1:0] limit;
	lct_pkg::cmd_t             cmd;
	lct_pkg::item_t            item;
	lct_pkg::item_t            q_mem_q [lct_pkg::Q_DEPTH];
	logic [lct_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [lct_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [lct_pkg::Q_AW:0]    fill_q;
	logic                      push;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ch_q <= lct_pkg::MAX_CH_RESET;
		end else if (cfg_we) begin
			max_ch_q <= cfg_wdata;
		end
	end

	// Clamp the limit to 1..CAPACITY
	always_comb begin
		if (max_ch_q == '0) begin
			limit = lct_pkg::CFG_W'(1);
		end else if (32'(max_ch_q) > CAPACITY) begin
			limit = lct_pkg::CFG_W'(CAPACITY);
		end else begin
			limit = max_ch_q;
		end
	end

	always_comb begin
		unique case (command)
			2'd0:    cmd = lct_pkg::CMD_OPEN;
			2'd1:    cmd = lct_pkg::CMD_TOUCH;
			2'd2:    cmd = lct_pkg::CMD_CLOSE;
			default: cmd = lct_pkg::CMD_NONE;
		endcase
		item.cmd   = cmd;
		item.id    = channel_id;
		item.limit = limit;
	end

	assign busy    = (fill_q == (lct_pkg::Q_AW+1)'(lct_pkg::Q_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (fill_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/lct_back.sv @@
// Back end: scans the entry RAM one slot a cycle for id match, LRU victim and
// first free slot, then updates the table and emits the result; an unknown
// command skips the scan. Depends on lct_pkg and lct_ram.
`timescale 1ns / 1ps
`default_nettype none

module lct_back #(
	parameter int CAPACITY = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               q_valid,
	input  wire lct_pkg::item_t                     q_item,
	output logic                                    q_pop,
	output logic                                    done,
	output logic                                    ok,
	output logic [lct_pkg::ID_W-1:0]                assigned_id,
	output logic                                    evicted,
	output logic [lct_pkg::ID_W-1:0]                evicted_id,
	output logic [$clog2(CAPACITY+1)-1:0]           open_count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	lct_pkg::bk_state_t state_q, state_d;
	lct_pkg::item_t     item_q;

	logic [IDX_W-1:0]             addr_q;
	logic                         cmp_vld_s1;
	logic [IDX_W-1:0]             cmp_idx_s1;
	logic [CAPACITY-1:0]          valid_q;
	logic [CAPACITY-1:0]          valid_d;
	logic [CNT_W-1:0]             count_q;
	logic [lct_pkg::ID_W-1:0]     next_id_q;
	logic [lct_pkg::STAMP_W-1:0]  use_cnt_q;

	logic                         match_found_q;
	logic [IDX_W-1:0]             match_idx_q;
	logic                         victim_found_q;
	logic [IDX_W-1:0]             victim_idx_q;
	logic [lct_pkg::STAMP_W-1:0]  victim_stamp_q;
	logic [lct_pkg::ID_W-1:0]     victim_id_q;
	logic                         free_found_q;
	logic [IDX_W-1:0]             free_idx_q;

	logic                         done_q;
	logic                         ok_q;
	logic [lct_pkg::ID_W-1:0]     assigned_id_q;
	logic                         evicted_q;
	logic [lct_pkg::ID_W-1:0]     evicted_id_q;
	logic [CNT_W-1:0]             open_count_q;

	logic                         ram_we;
	logic                         ram_re;
	logic [lct_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [lct_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [lct_pkg::ID_W-1:0]     rd_id;
	logic [lct_pkg::STAMP_W-1:0]  rd_stamp;
	logic                         ent_valid;

	logic                         take;
	logic                         is_open;
	logic                         evict;
	logic                         match_hit;
	logic                         use_victim;
	logic                         open_free;
	logic                         have_slot;
	logic                         add_entry;
	logic [IDX_W-1:0]             slot;
	logic [lct_pkg::STAMP_W-1:0]  fresh;
	logic [CNT_W-1:0]             new_count;

	lct_ram #(
		.WIDTH (lct_pkg::ENTRY_W),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign rd_id     = ram_rdata[lct_pkg::STAMP_W +: lct_pkg::ID_W];
	assign rd_stamp  = ram_rdata[lct_pkg::STAMP_W-1:0];
	assign ent_valid = valid_q[cmp_idx_s1];
	assign fresh     = use_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lct_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		ram_re  = 1'b0;
		take    = 1'b0;
		unique case (state_q)
			lct_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					take  = 1'b1;
					state_d = (q_item.cmd == lct_pkg::CMD_NONE) ?
						lct_pkg::BK_FINISH : lct_pkg::BK_SCAN;
				end
			end
			lct_pkg::BK_SCAN: begin
				ram_re = 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = lct_pkg::BK_DRAIN;
				end
			end
			lct_pkg::BK_DRAIN: begin
				state_d = lct_pkg::BK_FINISH;
			end
			lct_pkg::BK_FINISH: begin
				state_d = lct_pkg::BK_IDLE;
			end
			default: begin
				state_d = lct_pkg::BK_IDLE;
			end
		endcase
	end

	// Table update decisions, valid only in the finish state
	always_comb begin
		is_open    = (item_q.cmd == lct_pkg::CMD_OPEN);
		evict      = is_open && victim_found_q && (32'(count_q) >= 32'(item_q.limit));
		// the matching entry disappears if it is the one being evicted
		match_hit  = match_found_q && !(evict && (match_idx_q == victim_idx_q));
		use_victim = evict && (!free_found_q || (victim_idx_q < free_idx_q));
		open_free  = free_found_q || evict;
		have_slot  = match_hit || open_free;
		add_entry  = is_open && have_slot && !match_hit;
		if (is_open) begin
			slot = match_hit ? match_idx_q : (use_victim ? victim_idx_q : free_idx_q);
		end else begin
			slot = match_idx_q;
		end
		ram_wdata = {item_q.id, fresh};
		ram_we    = 1'b0;
		new_count = count_q;
		valid_d   = valid_q;
		if (state_q == lct_pkg::BK_FINISH) begin
			case (item_q.cmd)
				lct_pkg::CMD_OPEN: begin
					ram_we    = have_slot;
					new_count = count_q - CNT_W'(evict) + CNT_W'(add_entry);
					// clear the victim first; the new entry may reuse its slot
					if (evict) begin
						valid_d[victim_idx_q] = 1'b0;
					end
					if (have_slot) begin
						valid_d[slot] = 1'b1;
					end
				end
				lct_pkg::CMD_TOUCH: begin
					ram_we = match_found_q;
				end
				lct_pkg::CMD_CLOSE: begin
					new_count = count_q - CNT_W'(match_found_q);
					if (match_found_q) begin
						valid_d[match_idx_q] = 1'b0;
					end
				end
				default: begin
					new_count = count_q;
				end
			endcase
		end
	end

	// Scan pipeline and search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1     <= 1'b0;
			match_found_q  <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == lct_pkg::BK_SCAN);
			if (take) begin
				match_found_q  <= 1'b0;
				victim_found_q <= 1'b0;
				free_found_q   <= 1'b0;
			end else if (cmp_vld_s1) begin
				if (ent_valid && (rd_id == item_q.id) && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (ent_valid && (!victim_found_q || (rd_stamp < victim_stamp_q))) begin
					victim_found_q <= 1'b1;
				end
				if (!ent_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.cmd   <= q_item.cmd;
			item_q.limit <= q_item.limit;
			// open searches for the number it is about to give out
			item_q.id    <= (q_item.cmd == lct_pkg::CMD_OPEN) ? next_id_q : q_item.id;
			addr_q       <= '0;
		end else if (state_q == lct_pkg::BK_SCAN && addr_q != LAST_IDX) begin
			addr_q <= addr_q + 1'b1;
		end
		cmp_idx_s1 <= addr_q;
		if (cmp_vld_s1) begin
			if (ent_valid && (rd_id == item_q.id) && !match_found_q) begin
				match_idx_q <= cmp_idx_s1;
			end
			if (ent_valid && (!victim_found_q || (rd_stamp < victim_stamp_q))) begin
				victim_idx_q   <= cmp_idx_s1;
				victim_stamp_q <= rd_stamp;
				victim_id_q    <= rd_id;
			end
			if (!ent_valid && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			next_id_q <= '0;
			use_cnt_q <= '0;
		end else if (state_q == lct_pkg::BK_FINISH) begin
			count_q <= new_count;
			valid_q <= valid_d;
			if (ram_we) begin
				use_cnt_q <= fresh;
			end
			if (is_open) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == lct_pkg::BK_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lct_pkg::BK_FINISH) begin
			ok_q          <= is_open ||
				(match_found_q && (item_q.cmd == lct_pkg::CMD_TOUCH ||
				item_q.cmd == lct_pkg::CMD_CLOSE));
			assigned_id_q <= is_open ? item_q.id : '0;
			evicted_q     <= evict;
			evicted_id_q  <= evict ? victim_id_q : '0;
			open_count_q  <= new_count;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign assigned_id = assigned_id_q;
	assign evicted     = evicted_q;
	assign evicted_id  = evicted_id_q;
	assign open_count  = open_count_q;

endmodule

`default_nettype wire

@@ rtl/lru_channel_table_core.sv @@
// Top level of the LRU channel table: front end with command queue, back end
// with entry RAM. Depends on lct_pkg, lct_front, lct_back (and lct_ram).
//
//  port group   direction  handshake            payload
//  command      in         start / busy         command, channel_id
//  result       out        done (one cycle)     ok, assigned_id, evicted, evicted_id,
//                                               open_count
//  config       in         cfg_we               cfg_wdata (max_channels)
//
// Open, touch and close each run a one-entry-per-cycle scan of the entry RAM in the
// back end; an unknown command skips the scan. The back end takes one command at a time.
// A two-entry queue lets the front end take commands while the back end works;
// busy is high while the queue is full.
// Reset clears the valid bits, the open count and both counters; no clearing pass.
// Results are shown for one cycle with done and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module lru_channel_table_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       command,
	input  wire logic [lct_pkg::ID_W-1:0]         channel_id,
	input  wire logic                             cfg_we,
	input  wire logic [lct_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                                  done,
	output logic                                  ok,
	output logic [lct_pkg::ID_W-1:0]              assigned_id,
	output logic                                  evicted,
	output logic [lct_pkg::ID_W-1:0]              evicted_id,
	output logic [$clog2(CAPACITY+1)-1:0]         open_count
);

	logic           q_valid;
	logic           q_pop;
	lct_pkg::item_t q_item;

	lct_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.channel_id (channel_id),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	lct_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.done        (done),
		.ok          (ok),
		.assigned_id (assigned_id),
		.evicted     (evicted),
		.evicted_id  (evicted_id),
		.open_count  (open_count)
	);

endmodule

`default_nettype wire

@@ tb/tb_lru_channel_table_core.sv @@
// Testbench for lru_channel_table_core: a queue-fed command driver, a result monitor
// and a table predictor that tracks entries, stamps and the channel limit.
// Depends on lct_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_lru_channel_table_core;

	localparam int TBL_DEPTH = 16;
	localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
	localparam int ID_W      = lct_pkg::ID_W;
	localparam int STAMP_W   = lct_pkg::STAMP_W;
	localparam int CFG_W     = lct_pkg::CFG_W;

	typedef struct {
		lct_pkg::cmd_t   cmd;
		logic [ID_W-1:0] id;
	} request_t;

	typedef struct {
		logic             ok;
		logic [ID_W-1:0]  assigned_id;
		logic             evicted;
		logic [ID_W-1:0]  evicted_id;
		logic [CNT_W-1:0] open_count;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          command = 2'd0;
	logic [ID_W-1:0]     channel_id = '0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                done;
	logic                ok;
	logic [ID_W-1:0]     assigned_id;
	logic                evicted;
	logic [ID_W-1:0]     evicted_id;
	logic [CNT_W-1:0]    open_count;

	request_t cmd_pending[$];
	outcome_t result_due[$];
	int       errors = 0;
	int       gap_left;
	int       idle_max = 5;
	int       opens_issued = 0;

	// Predictor state
	logic              chan_valid [TBL_DEPTH];
	logic [ID_W-1:0]   chan_id    [TBL_DEPTH];
	logic [STAMP_W-1:0] chan_stamp [TBL_DEPTH];
	logic [ID_W-1:0]   next_chan = '0;
	logic [STAMP_W-1:0] use_ctr = '0;
	logic [CFG_W-1:0]  limit_reg = lct_pkg::MAX_CH_RESET;

	logic [CFG_W-1:0] limit_plan [0:9] = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd17,
		5'd8, 5'd2, 5'd16, 5'd5, 5'd12};

	lru_channel_table_core #(
		.CAPACITY(TBL_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.channel_id(channel_id),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.ok(ok),
		.assigned_id(assigned_id),
		.evicted(evicted),
		.evicted_id(evicted_id),
		.open_count(open_count)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < TBL_DEPTH; i++) begin
			chan_valid[i] = 1'b0;
			chan_id[i] = '0;
			chan_stamp[i] = '0;
		end
	end

	function automatic int count_open();
		int n;
		n = 0;
		for (int i = 0; i < TBL_DEPTH; i++)
			if (chan_valid[i])
				n++;
		return n;
	endfunction

	function automatic int find_chan(logic [ID_W-1:0] id);
		int hit;
		hit = -1;
		for (int i = 0; i < TBL_DEPTH; i++)
			if (hit < 0 && chan_valid[i] && chan_id[i] == id)
				hit = i;
		return hit;
	endfunction

	// Apply one transaction to the predicted table and return its result
	function automatic outcome_t table_step(lct_pkg::cmd_t c, logic [ID_W-1:0] cid);
		outcome_t r;
		int lim;
		int victim;
		int slot;
		logic [ID_W-1:0] nid;
		r = '{default: '0};
		lim = int'(limit_reg);
		if (lim < 1)
			lim = 1;
		if (lim > TBL_DEPTH)
			lim = TBL_DEPTH;
		case (c)
			lct_pkg::CMD_OPEN: begin
				if (count_open() >= lim) begin
					victim = -1;
					for (int i = 0; i < TBL_DEPTH; i++)
						if (chan_valid[i] && (victim < 0 || chan_stamp[i] < chan_stamp[victim]))
							victim = i;
					if (victim >= 0) begin
						chan_valid[victim] = 1'b0;
						r.evicted = 1'b1;
						r.evicted_id = chan_id[victim];
					end
				end
				nid = next_chan;
				next_chan = next_chan + 1'b1;
				slot = find_chan(nid);
				// reuse an entry already holding this number, else take the first free one
				for (int i = 0; i < TBL_DEPTH; i++)
					if (slot < 0 && !chan_valid[i])
						slot = i;
				if (slot >= 0) begin
					use_ctr = use_ctr + 1'b1;
					chan_valid[slot] = 1'b1;
					chan_id[slot] = nid;
					chan_stamp[slot] = use_ctr;
				end
				r.ok = 1'b1;
				r.assigned_id = nid;
			end
			lct_pkg::CMD_TOUCH: begin
				slot = find_chan(cid);
				if (slot >= 0) begin
					use_ctr = use_ctr + 1'b1;
					chan_stamp[slot] = use_ctr;
					r.ok = 1'b1;
				end
			end
			lct_pkg::CMD_CLOSE: begin
				slot = find_chan(cid);
				if (slot >= 0) begin
					chan_valid[slot] = 1'b0;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.open_count = CNT_W'(count_open());
		return r;
	endfunction

	task automatic queue_request(lct_pkg::cmd_t c, logic [ID_W-1:0] id);
		request_t rq;
		rq.cmd = c;
		rq.id = id;
		cmd_pending.push_back(rq);
		if (c == lct_pkg::CMD_OPEN)
			opens_issued++;
	endtask

	// Mostly target channels that are likely held; some random and edge numbers
	task automatic queue_random();
		int pick;
		int sel;
		int base;
		logic [ID_W-1:0] id;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 9);
		base = opens_issued - int'($urandom_range(0, 20));
		if (base < 0)
			base = 0;
		if (sel == 0)
			id = $urandom();
		else if (sel == 1)
			id = '1;
		else
			id = ID_W'(base);
		if (pick < 45)
			queue_request(lct_pkg::CMD_OPEN, $urandom());
		else if (pick < 75)
			queue_request(lct_pkg::CMD_TOUCH, id);
		else if (pick < 95)
			queue_request(lct_pkg::CMD_CLOSE, id);
		else
			queue_request(lct_pkg::CMD_NONE, $urandom());
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_cmds
		request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_pending.size() != 0) begin
				nxt = cmd_pending.pop_front();
				start <= 1'b1;
				command <= nxt.cmd;
				channel_id <= nxt.id;
				gap_left <= $urandom_range(0, idle_max);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (result_due.size() == 0) begin
					$error("result with no transaction pending");
					errors++;
				end else begin
					want = result_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						errors++;
					end
					if (assigned_id !== want.assigned_id) begin
						$error("assigned_id: expected %0d, got %0d", want.assigned_id, assigned_id);
						errors++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, evicted);
						errors++;
					end
					if (evicted_id !== want.evicted_id) begin
						$error("evicted_id: expected %0d, got %0d", want.evicted_id, evicted_id);
						errors++;
					end
					if (open_count !== want.open_count) begin
						$error("open_count: expected %0d, got %0d", want.open_count, open_count);
						errors++;
					end
				end
			end
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (start && !busy)
				result_due.push_back(table_step(lct_pkg::cmd_t'(command), channel_id));
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lookups on an empty table, unknown command, then fill past the reset limit
		queue_request(lct_pkg::CMD_TOUCH, '0);
		queue_request(lct_pkg::CMD_CLOSE, '0);
		queue_request(lct_pkg::CMD_NONE, '1);
		queue_request(lct_pkg::CMD_TOUCH, '1);
		repeat (17)
			queue_request(lct_pkg::CMD_OPEN, $urandom());
		queue_request(lct_pkg::CMD_TOUCH, 32'd1);
		queue_request(lct_pkg::CMD_CLOSE, 32'd5);
		queue_request(lct_pkg::CMD_CLOSE, 32'd5);
		queue_request(lct_pkg::CMD_OPEN, '1);

		// First setting lowers the limit below the open count
		for (int ph = 0; ph < 10; ph++) begin
			while (cmd_pending.size() != 0 || start || result_due.size() != 0)
				@(negedge clk);
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= limit_plan[ph];
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			idle_max = (ph % 2 == 1) ? 0 : 5;
			repeat (88)
				queue_random();
		end

		while (cmd_pending.size() != 0 || start || result_due.size() != 0)
			@(negedge clk);
		repeat (TBL_DEPTH + 8) @(negedge clk);
		if (errors == 0 && result_due.size() == 0)
			$display("[lru_channel_table_core] OK");
		else
			$display("[lru_channel_table_core] ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("[lru_channel_table_core] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lct_pkg.sv
rtl/lct_ram.sv
rtl/lct_front.sv
rtl/lct_back.sv
rtl/lru_channel_table_core.sv
tb/tb_lru_channel_table_core.sv
